/* rtl/dcesg_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the DC motor end-stop seek guard.
// Used by every module of the block; depends on nothing else.
package dcesg_pkg;

    localparam int unsigned TIME_W             = 32;
    localparam int unsigned NO_LOAD_FLOOR_MA   = 30;
    localparam int unsigned NO_LOAD_CONFIRM_MS = 200;
    localparam int unsigned MIN_FLOOR_MA       = 50;
    localparam int unsigned PCT                = 100;
    localparam logic [15:0] ALL_ONES16         = 16'hFFFF;
    localparam logic [1:0]  POS_UNKNOWN        = 2'd0;

    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned M_TDATA_W = 64;

    typedef enum logic [2:0] {
        CMD_TICK  = 3'd0,
        CMD_DRIVE = 3'd1,
        CMD_BRAKE = 3'd2,
        CMD_COAST = 3'd3,
        CMD_SEEK  = 3'd4,
        CMD_CLEAR = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SEEK    = 2'd1,
        PH_REACHED = 2'd2,
        PH_FAULT   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        DRV_DRIVE = 2'd0,
        DRV_BRAKE = 2'd1,
        DRV_COAST = 2'd2
    } t_drive;

    typedef enum logic [2:0] {
        EV_NONE       = 3'd0,
        EV_REACHED    = 3'd1,
        EV_ABORTED    = 3'd2,
        EV_TIMEOUT    = 3'd3,
        EV_NO_LOAD    = 3'd4,
        EV_FREE_STALL = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        CFG_GUARD_MODE = 3'd0,
        CFG_STALL_THR  = 3'd1,
        CFG_WINDOW     = 3'd2,
        CFG_RATIO      = 3'd3,
        CFG_RUN_SAMPLE = 3'd4,
        CFG_INRUSH     = 3'd5,
        CFG_MAX_TRAVEL = 3'd6,
        CFG_ABS_MAX    = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic        guard_mode;
        logic [15:0] stall_threshold_ma;
        logic [15:0] stall_window_ms;
        logic [15:0] trip_ratio_pct;
        logic [15:0] run_sample_ms;
        logic [15:0] inrush_blank_ms;
        logic [15:0] max_travel_ms;
        logic [15:0] abs_max_ma;
    } t_cfg;

    typedef struct packed {
        t_cmd               command;
        logic signed [15:0] cur_sample_ma;
        logic signed [15:0] duty;
        logic [1:0]         target_end;
        logic [15:0]        seek_limit_ms;
    } t_item;

    typedef struct packed {
        t_drive             drive_mode;
        logic signed [15:0] drive_duty;
        t_event             event_res;
        logic [15:0]        travel_ms;
        logic [15:0]        peak_ma;
        logic [1:0]         position;
        t_phase             seek_status;
        logic               stalled;
    } t_result;

    // Over-threshold tracker state shared by the seek guard and the free-run guard.
    typedef struct packed {
        logic              active;
        logic [TIME_W-1:0] start;
        logic [15:0]       peak;
    } t_over_st;

    typedef struct packed {
        logic        thr_ok;
        logic        over;
        logic [15:0] tmin;
    } t_ratio;

endpackage

/* rtl/dcesg_ratio.sv */
`timescale 1ns / 1ps
// Live-ratio stall threshold compare: trailing minimum, floor, ratio and ceiling.
// Depends on dcesg_pkg.
module dcesg_ratio (
    input  logic [16:0]          i_mag,
    input  logic [15:0]          i_tmin,
    input  logic [15:0]          i_ratio,
    input  logic [15:0]          i_abs_max,
    output dcesg_pkg::t_ratio    o_ratio
);
    import dcesg_pkg::*;

    logic [15:0] tmin_new;
    logic [15:0] base;
    logic [31:0] prod;
    logic [23:0] mag_x100;
    logic [22:0] cap_x100;
    logic        capped;

    // The threshold is floor(base * ratio / 100). Instead of dividing, both sides
    // of each compare are scaled by 100: mag >= floor(P/100) iff 100*mag + 99 >= P,
    // and ceiling < floor(P/100) iff 100*(ceiling + 1) <= P.
    always_comb begin
        tmin_new = (i_mag < {1'b0, i_tmin}) ? i_mag[15:0] : i_tmin;
        base     = (tmin_new < 16'(MIN_FLOOR_MA)) ? 16'(MIN_FLOOR_MA) : tmin_new;
        prod     = 32'(base) * 32'(i_ratio);
        mag_x100 = 24'(i_mag) * 24'(PCT) + 24'(PCT - 1);
        cap_x100 = (23'(i_abs_max) + 23'd1) * 23'(PCT);
        capped   = (i_abs_max != 16'd0) && (32'(cap_x100) <= prod);

        o_ratio.tmin   = tmin_new;
        o_ratio.thr_ok = prod >= 32'(PCT);
        o_ratio.over   = capped ? (i_mag >= 17'(i_abs_max)) : (32'(mag_x100) >= prod);
    end

endmodule

/* rtl/dcesg_over.sv */
`timescale 1ns / 1ps
// Over-threshold window tracker: start time, peak magnitude and stall confirm.
// Depends on dcesg_pkg.
module dcesg_over (
    input  logic                          i_en,
    input  logic                          i_thr_ok,
    input  logic                          i_over,
    input  logic [16:0]                   i_mag,
    input  logic [dcesg_pkg::TIME_W-1:0]  i_time,
    input  logic [15:0]                   i_window,
    input  dcesg_pkg::t_over_st           i_st,
    output dcesg_pkg::t_over_st           o_st,
    output logic                          o_confirm
);
    import dcesg_pkg::*;

    always_comb begin
        o_st      = i_st;
        o_confirm = 1'b0;
        if (i_en && i_thr_ok) begin
            if (i_over) begin
                if (!i_st.active) begin
                    o_st.active = 1'b1;
                    o_st.start  = i_time;
                    o_st.peak   = i_mag[15:0];
                end else begin
                    if (i_mag > {1'b0, i_st.peak}) begin
                        o_st.peak = i_mag[15:0];
                    end
                    o_confirm = (i_time - i_st.start) >= TIME_W'(i_window);
                end
            end else begin
                o_st.active = 1'b0;
                o_st.peak   = 16'd0;
            end
        end
    end

endmodule

/* rtl/dcesg_ctrl.sv */
`timescale 1ns / 1ps
// Seek and guard state with the per-transaction next-state and result logic.
// Depends on dcesg_pkg, dcesg_ratio and dcesg_over.
module dcesg_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  dcesg_pkg::t_item      i_item,
    input  dcesg_pkg::t_cfg       i_cfg,
    output dcesg_pkg::t_result    o_res
);
    import dcesg_pkg::*;

    logic [TIME_W-1:0] r_time, n_time;
    t_phase            r_phase, n_phase;
    logic [TIME_W-1:0] r_seek_start, n_seek_start;
    logic [15:0]       r_deadline, n_deadline;
    logic [1:0]        r_target, n_target;
    logic [1:0]        r_pos, n_pos;
    logic [15:0]       r_duty, n_duty;
    t_drive            r_mode, n_mode;
    t_over_st          r_over, n_over;
    logic [15:0]       r_tmin, n_tmin;
    logic              r_low_active, n_low_active;
    logic [TIME_W-1:0] r_low_start, n_low_start;
    logic              r_stall, n_stall;

    logic [TIME_W-1:0] t1;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] cancel_travel;
    logic [16:0]       mag;
    logic              is_seek;
    logic              blank_ok;
    logic              armed;
    logic              is_low;
    logic              nl_fault;
    logic [1:0]        target;
    t_ratio            ratio;
    logic              ov_en;
    logic              ov_thr_ok;
    logic              ov_over;
    t_over_st          ov_st;
    logic              ov_confirm;
    t_event            ev;
    logic [15:0]       ev_travel;
    logic [15:0]       ev_peak;

    assign t1            = r_time + TIME_W'(1);
    assign elapsed       = t1 - r_seek_start;
    assign cancel_travel = r_time - r_seek_start;
    assign mag           = i_item.cur_sample_ma[15]
                           ? (17'h10000 - {1'b0, i_item.cur_sample_ma})
                           : {1'b0, i_item.cur_sample_ma};
    assign is_seek       = (r_phase == PH_SEEK);
    assign blank_ok      = elapsed >= TIME_W'(i_cfg.inrush_blank_ms);
    assign armed         = elapsed >= TIME_W'({1'b0, i_cfg.inrush_blank_ms}
                                              + {1'b0, i_cfg.run_sample_ms});
    assign is_low        = mag < 17'(NO_LOAD_FLOOR_MA);
    assign nl_fault      = (NO_LOAD_FLOOR_MA != 0) && blank_ok && is_low && r_low_active
                           && ((t1 - r_low_start) >= TIME_W'(NO_LOAD_CONFIRM_MS));
    assign target        = (i_item.target_end == 2'd3) ? POS_UNKNOWN : i_item.target_end;

    dcesg_ratio u_ratio (
        .i_mag     (mag),
        .i_tmin    (r_tmin),
        .i_ratio   (i_cfg.trip_ratio_pct),
        .i_abs_max (i_cfg.abs_max_ma),
        .o_ratio   (ratio)
    );

    // One tracker serves both guards; seeking and free running never overlap.
    always_comb begin
        if (is_seek) begin
            ov_en     = (i_item.command == CMD_TICK) && (!i_cfg.guard_mode || armed);
            ov_thr_ok = i_cfg.guard_mode ? ratio.thr_ok : (i_cfg.stall_threshold_ma != 16'd0);
            ov_over   = i_cfg.guard_mode ? ratio.over
                                         : (mag >= 17'(i_cfg.stall_threshold_ma));
        end else begin
            ov_en     = (i_item.command == CMD_TICK) && !i_cfg.guard_mode && !r_stall;
            ov_thr_ok = i_cfg.stall_threshold_ma != 16'd0;
            ov_over   = mag >= 17'(i_cfg.stall_threshold_ma);
        end
    end

    dcesg_over u_over (
        .i_en      (ov_en),
        .i_thr_ok  (ov_thr_ok),
        .i_over    (ov_over),
        .i_mag     (mag),
        .i_time    (t1),
        .i_window  (i_cfg.stall_window_ms),
        .i_st      (r_over),
        .o_st      (ov_st),
        .o_confirm (ov_confirm)
    );

    always_comb begin
        n_time       = r_time;
        n_phase      = r_phase;
        n_seek_start = r_seek_start;
        n_deadline   = r_deadline;
        n_target     = r_target;
        n_pos        = r_pos;
        n_duty       = r_duty;
        n_mode       = r_mode;
        n_over       = r_over;
        n_tmin       = r_tmin;
        n_low_active = r_low_active;
        n_low_start  = r_low_start;
        n_stall      = r_stall;
        ev           = EV_NONE;
        ev_travel    = 16'd0;
        ev_peak      = 16'd0;

        unique case (i_item.command) inside
            CMD_TICK: begin
                n_time = t1;
                if (is_seek) begin
                    if (blank_ok) begin
                        if (is_low) begin
                            if (!r_low_active) begin
                                n_low_active = 1'b1;
                                n_low_start  = t1;
                            end
                        end else begin
                            n_low_active = 1'b0;
                        end
                    end
                    if (nl_fault) begin
                        n_mode    = DRV_BRAKE;
                        n_duty    = 16'd0;
                        n_phase   = PH_FAULT;
                        n_pos     = POS_UNKNOWN;
                        ev        = EV_NO_LOAD;
                        ev_travel = elapsed[15:0];
                    end else begin
                        if (i_cfg.guard_mode && blank_ok) begin
                            n_tmin = ratio.tmin;
                        end
                        n_over = ov_st;
                        if (ov_confirm) begin
                            n_mode    = DRV_BRAKE;
                            n_duty    = 16'd0;
                            n_stall   = 1'b1;
                            n_phase   = PH_REACHED;
                            if (r_target != POS_UNKNOWN) begin
                                n_pos = r_target;
                            end
                            ev        = EV_REACHED;
                            ev_travel = elapsed[15:0];
                            ev_peak   = ov_st.peak;
                        end else if ((r_deadline != 16'd0)
                                     && (elapsed >= TIME_W'(r_deadline))) begin
                            n_mode    = DRV_BRAKE;
                            n_duty    = 16'd0;
                            n_phase   = PH_FAULT;
                            n_pos     = POS_UNKNOWN;
                            ev        = EV_TIMEOUT;
                            ev_travel = elapsed[15:0];
                        end
                    end
                end else begin
                    n_over = ov_st;
                    if (ov_confirm) begin
                        n_stall = 1'b1;
                        ev      = EV_FREE_STALL;
                        ev_peak = ov_st.peak;
                    end
                end
            end
            CMD_DRIVE: begin
                if (is_seek) begin
                    n_phase   = PH_IDLE;
                    ev        = EV_ABORTED;
                    ev_travel = cancel_travel[15:0];
                end
                n_duty = i_item.duty;
                n_mode = DRV_DRIVE;
                if (i_item.duty == 16'sd0) begin
                    n_over.active = 1'b0;
                    n_over.peak   = 16'd0;
                end
            end
            CMD_BRAKE, CMD_COAST: begin
                if (is_seek) begin
                    ev        = EV_ABORTED;
                    ev_travel = cancel_travel[15:0];
                end
                n_phase       = PH_IDLE;
                n_duty        = 16'd0;
                n_mode        = (i_item.command == CMD_BRAKE) ? DRV_BRAKE : DRV_COAST;
                n_stall       = 1'b0;
                n_over.active = 1'b0;
                n_over.peak   = 16'd0;
            end
            CMD_SEEK: begin
                if (i_item.duty == 16'sd0) begin
                    // A seek with no drive is taken as already at the end.
                    if (target != POS_UNKNOWN) begin
                        n_pos = target;
                    end
                    n_phase = PH_REACHED;
                    ev      = EV_REACHED;
                end else begin
                    n_phase      = PH_SEEK;
                    n_seek_start = r_time;
                    n_target     = target;
                    n_deadline   = i_item.seek_limit_ms;
                    if (i_cfg.guard_mode && (i_cfg.max_travel_ms != 16'd0)
                        && ((i_item.seek_limit_ms == 16'd0)
                            || (i_cfg.max_travel_ms < i_item.seek_limit_ms))) begin
                        n_deadline = i_cfg.max_travel_ms;
                    end
                    n_stall       = 1'b0;
                    n_over.active = 1'b0;
                    n_over.peak   = 16'd0;
                    n_tmin        = ALL_ONES16;
                    n_low_active  = 1'b0;
                    n_duty        = i_item.duty;
                    n_mode        = DRV_DRIVE;
                end
            end
            CMD_CLEAR: begin
                n_stall       = 1'b0;
                n_over.active = 1'b0;
                n_over.peak   = 16'd0;
                if ((r_phase == PH_REACHED) || (r_phase == PH_FAULT)) begin
                    n_phase = PH_IDLE;
                end
            end
            default: begin
            end
        endcase

        o_res.drive_mode  = n_mode;
        o_res.drive_duty  = n_duty;
        o_res.event_res   = ev;
        o_res.travel_ms   = ev_travel;
        o_res.peak_ma     = (ev == EV_NONE) ? n_over.peak : ev_peak;
        o_res.position    = n_pos;
        o_res.seek_status = n_phase;
        o_res.stalled     = n_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time       <= '0;
            r_phase      <= PH_IDLE;
            r_seek_start <= '0;
            r_deadline   <= '0;
            r_target     <= POS_UNKNOWN;
            r_pos        <= POS_UNKNOWN;
            r_duty       <= '0;
            r_mode       <= DRV_COAST;
            r_over       <= '0;
            r_tmin       <= ALL_ONES16;
            r_low_active <= 1'b0;
            r_low_start  <= '0;
            r_stall      <= 1'b0;
        end else if (i_step) begin
            r_time       <= n_time;
            r_phase      <= n_phase;
            r_seek_start <= n_seek_start;
            r_deadline   <= n_deadline;
            r_target     <= n_target;
            r_pos        <= n_pos;
            r_duty       <= n_duty;
            r_mode       <= n_mode;
            r_over       <= n_over;
            r_tmin       <= n_tmin;
            r_low_active <= n_low_active;
            r_low_start  <= n_low_start;
            r_stall      <= n_stall;
        end
    end

endmodule

/* rtl/dc_motor_endstop_seek_guard.sv */
`timescale 1ns / 1ps
// DC motor end-stop seek guard: input register, control update, result register.
// The result register loads when the held input steps, once the output is empty or taken.
// Throughput: one command per clock cycle while m_tready keeps the output draining.
// While a finished result waits on m_tready, the input register takes one more transaction.
// Synchronous active-low reset clears valid and control state and loads register defaults.
// Depends on dcesg_pkg and dcesg_ctrl.
module dc_motor_endstop_seek_guard (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cur_sample_ma[15:0], duty[31:16], target_end[33:32], seek_limit_ms[49:34], zeros
    input  logic [dcesg_pkg::S_TDATA_W-1:0]    s_tdata,
    // command[2:0]
    input  logic [2:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // drive_mode[1:0], drive_duty[17:2], event_res[20:18], travel_ms[36:21],
    // peak_ma[52:37], position[54:53], seek_status[56:55], stalled[57], zeros
    output logic [dcesg_pkg::M_TDATA_W-1:0]    m_tdata,
    input  logic                               i_cfg_we,
    input  logic [2:0]                         i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);
    import dcesg_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_m_valid;
    t_result r_res;
    t_result res;
    logic    step;

    assign step     = r_in_valid && (!r_m_valid || m_tready);
    assign s_tready = !r_in_valid || step;
    assign m_tvalid = r_m_valid;
    assign m_tdata  = {6'd0, r_res.stalled, r_res.seek_status, r_res.position,
                       r_res.peak_ma, r_res.travel_ms, r_res.event_res,
                       r_res.drive_duty, r_res.drive_mode};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.guard_mode         <= 1'b0;
            r_cfg.stall_threshold_ma <= 16'd0;
            r_cfg.stall_window_ms    <= 16'd250;
            r_cfg.trip_ratio_pct     <= 16'd250;
            r_cfg.run_sample_ms      <= 16'd200;
            r_cfg.inrush_blank_ms    <= 16'd150;
            r_cfg.max_travel_ms      <= 16'd0;
            r_cfg.abs_max_ma         <= 16'd0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GUARD_MODE: r_cfg.guard_mode         <= i_cfg_data[0];
                CFG_STALL_THR:  r_cfg.stall_threshold_ma <= i_cfg_data;
                CFG_WINDOW:     r_cfg.stall_window_ms    <= i_cfg_data;
                CFG_RATIO:      r_cfg.trip_ratio_pct     <= i_cfg_data;
                CFG_RUN_SAMPLE: r_cfg.run_sample_ms      <= i_cfg_data;
                CFG_INRUSH:     r_cfg.inrush_blank_ms    <= i_cfg_data;
                CFG_MAX_TRAVEL: r_cfg.max_travel_ms      <= i_cfg_data;
                CFG_ABS_MAX:    r_cfg.abs_max_ma         <= i_cfg_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in.command       <= t_cmd'(s_tuser);
            r_in.cur_sample_ma <= s_tdata[15:0];
            r_in.duty          <= s_tdata[31:16];
            r_in.target_end    <= s_tdata[33:32];
            r_in.seek_limit_ms <= s_tdata[49:34];
        end
    end

    dcesg_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (step) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

endmodule

/* sim/dc_motor_endstop_seek_guard_tb.sv */
`timescale 1ns / 1ps
// Self-checking bench for the DC motor end-stop seek guard: directed commands, then
// shaped random strokes over several register settings, checked against a local model.
// Depends on dcesg_pkg and the dc_motor_endstop_seek_guard RTL.
module dc_motor_endstop_seek_guard_tb;
    import dcesg_pkg::*;

    localparam int          CYCLE_LIMIT = 500000;
    localparam int          HOLD_CYCLES = 400;
    localparam logic [2:0]  CMD_SPARE6  = 3'd6;
    localparam logic [2:0]  CMD_SPARE7  = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [15:0] cur;
        logic [15:0] duty;
        logic [1:0]  tgt;
        logic [15:0] tmo;
    } motor_cmd_t;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [2:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  i_cfg_we;
    logic [2:0]            i_cfg_index;
    logic [15:0]           i_cfg_data;

    dc_motor_endstop_seek_guard dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Local copy of the guard registers and the controller state.
    t_cfg        gcfg;
    logic [31:0] now_ms, seek_t0, over_t0, low_t0;
    logic [16:0] deadline_ms;
    t_phase      phase_q;
    t_drive      drive_q;
    logic [1:0]  seek_goal, end_pos;
    logic [15:0] duty_q, peak_q, floor_min;
    bit          over_on, low_on, stall_q;
    t_event      ev_code;
    logic [15:0] ev_travel, ev_peak;

    motor_cmd_t  cmd_backlog[$];
    t_result     status_due[$];
    motor_cmd_t  on_bus;
    int          n_queued, n_offered, n_taken, n_status, n_status_seen;
    int          tx_wait, rx_wait, rx_hold_left, tx_idle_pct, rx_idle_pct;
    int          hold_req, hold_ack, mismatches, cycle_cnt;

    function automatic void reset_model();
        gcfg.guard_mode         = 1'b0;
        gcfg.stall_threshold_ma = 16'd0;
        gcfg.stall_window_ms    = 16'd250;
        gcfg.trip_ratio_pct     = 16'd250;
        gcfg.run_sample_ms      = 16'd200;
        gcfg.inrush_blank_ms    = 16'd150;
        gcfg.max_travel_ms      = 16'd0;
        gcfg.abs_max_ma         = 16'd0;
        now_ms      = '0;
        seek_t0     = '0;
        over_t0     = '0;
        low_t0      = '0;
        deadline_ms = '0;
        phase_q     = PH_IDLE;
        drive_q     = DRV_COAST;
        seek_goal   = POS_UNKNOWN;
        end_pos     = POS_UNKNOWN;
        duty_q      = '0;
        peak_q      = '0;
        floor_min   = ALL_ONES16;
        over_on     = 1'b0;
        low_on      = 1'b0;
        stall_q     = 1'b0;
    endfunction

    function automatic void post_event(t_event code, logic [31:0] travel, logic [15:0] pk);
        ev_code   = code;
        ev_travel = travel[15:0];
        ev_peak   = pk;
    endfunction

    function automatic void abort_seek();
        if (phase_q == PH_SEEK) begin
            phase_q = PH_IDLE;
            post_event(EV_ABORTED, now_ms - seek_t0, 16'd0);
        end
    endfunction

    function automatic void release_stall();
        stall_q = 1'b0;
        over_on = 1'b0;
        peak_q  = '0;
        if (phase_q == PH_FAULT || phase_q == PH_REACHED)
            phase_q = PH_IDLE;
    endfunction

    // Tracks a run of samples at or over thr; true once the run has lasted the window.
    function automatic bit over_window(logic [16:0] mag, logic [31:0] thr);
        if (mag >= thr) begin
            if (!over_on) begin
                over_on = 1'b1;
                over_t0 = now_ms;
                peak_q  = mag[15:0];
            end else begin
                if (mag > peak_q)
                    peak_q = mag[15:0];
                if (now_ms - over_t0 >= gcfg.stall_window_ms)
                    return 1'b1;
            end
        end else begin
            over_on = 1'b0;
            peak_q  = '0;
        end
        return 1'b0;
    endfunction

    function automatic void land_on_stop(logic [31:0] elapsed);
        drive_q = DRV_BRAKE;
        duty_q  = '0;
        stall_q = 1'b1;
        phase_q = PH_REACHED;
        if (seek_goal != POS_UNKNOWN)
            end_pos = seek_goal;
        post_event(EV_REACHED, elapsed, peak_q);
    endfunction

    function automatic void halt_fault(t_event code, logic [31:0] elapsed);
        drive_q = DRV_BRAKE;
        duty_q  = '0;
        phase_q = PH_FAULT;
        end_pos = POS_UNKNOWN;
        post_event(code, elapsed, 16'd0);
    endfunction

    // Applies one command to the local state and returns the status it reports.
    function automatic t_result advance_motor(motor_cmd_t c);
        t_result     r;
        logic [1:0]  goal;
        logic [16:0] mag;
        logic [31:0] elapsed, thr, prod;
        logic [15:0] base;
        bit          done;
        goal      = (c.tgt == 2'd3) ? POS_UNKNOWN : c.tgt;
        mag       = c.cur[15] ? (17'h10000 - {1'b0, c.cur}) : {1'b0, c.cur};
        ev_code   = EV_NONE;
        ev_travel = '0;
        ev_peak   = '0;
        done      = 1'b0;
        case (c.cmd) inside
            CMD_TICK: begin
                now_ms = now_ms + 32'd1;
                if (phase_q == PH_SEEK) begin
                    elapsed = now_ms - seek_t0;
                    if (NO_LOAD_FLOOR_MA != 0 && elapsed >= gcfg.inrush_blank_ms) begin
                        if (mag < NO_LOAD_FLOOR_MA) begin
                            if (!low_on) begin
                                low_on = 1'b1;
                                low_t0 = now_ms;
                            end else if (now_ms - low_t0 >= NO_LOAD_CONFIRM_MS) begin
                                halt_fault(EV_NO_LOAD, elapsed);
                                done = 1'b1;
                            end
                        end else begin
                            low_on = 1'b0;
                        end
                    end
                    if (!done) begin
                        if (gcfg.guard_mode) begin
                            if (elapsed >= gcfg.inrush_blank_ms) begin
                                if (mag < floor_min)
                                    floor_min = mag[15:0];
                                if (elapsed >= gcfg.inrush_blank_ms + gcfg.run_sample_ms) begin
                                    base = (floor_min < MIN_FLOOR_MA) ? 16'(MIN_FLOOR_MA)
                                                                      : floor_min;
                                    prod = 32'(base) * 32'(gcfg.trip_ratio_pct);
                                    thr  = prod / PCT;
                                    if (thr > ALL_ONES16)
                                        thr = ALL_ONES16;
                                    if (gcfg.abs_max_ma != 0 && gcfg.abs_max_ma < thr)
                                        thr = gcfg.abs_max_ma;
                                    if (thr != 0 && over_window(mag, thr)) begin
                                        land_on_stop(elapsed);
                                        done = 1'b1;
                                    end
                                end
                            end
                        end else if (gcfg.stall_threshold_ma != 0) begin
                            if (over_window(mag, gcfg.stall_threshold_ma)) begin
                                land_on_stop(elapsed);
                                done = 1'b1;
                            end
                        end
                    end
                    if (!done && deadline_ms != 0 && elapsed >= deadline_ms)
                        halt_fault(EV_TIMEOUT, elapsed);
                end else if (!gcfg.guard_mode && gcfg.stall_threshold_ma != 0 && !stall_q) begin
                    if (over_window(mag, gcfg.stall_threshold_ma)) begin
                        stall_q = 1'b1;
                        post_event(EV_FREE_STALL, 32'd0, peak_q);
                    end
                end
            end
            CMD_DRIVE: begin
                abort_seek();
                duty_q  = c.duty;
                drive_q = DRV_DRIVE;
                if (c.duty == 0) begin
                    over_on = 1'b0;
                    peak_q  = '0;
                end
            end
            CMD_BRAKE, CMD_COAST: begin
                abort_seek();
                duty_q = '0;
                if (c.cmd == CMD_BRAKE)
                    drive_q = DRV_BRAKE;
                else
                    drive_q = DRV_COAST;
                release_stall();
            end
            CMD_SEEK: begin
                if (c.duty == 0) begin
                    // A zero-duty seek just declares the target reached.
                    if (goal != POS_UNKNOWN)
                        end_pos = goal;
                    phase_q = PH_REACHED;
                    post_event(EV_REACHED, 32'd0, 16'd0);
                end else begin
                    phase_q     = PH_SEEK;
                    seek_t0     = now_ms;
                    seek_goal   = goal;
                    deadline_ms = {1'b0, c.tmo};
                    if (gcfg.guard_mode && gcfg.max_travel_ms != 0 &&
                        (deadline_ms == 0 || gcfg.max_travel_ms < deadline_ms))
                        deadline_ms = {1'b0, gcfg.max_travel_ms};
                    stall_q   = 1'b0;
                    over_on   = 1'b0;
                    peak_q    = '0;
                    floor_min = ALL_ONES16;
                    low_on    = 1'b0;
                    duty_q    = c.duty;
                    drive_q   = DRV_DRIVE;
                end
            end
            CMD_CLEAR: release_stall();
            default: ;
        endcase
        if (ev_code == EV_NONE)
            ev_peak = peak_q;
        r.drive_mode  = drive_q;
        r.drive_duty  = duty_q;
        r.event_res   = ev_code;
        r.travel_ms   = ev_travel;
        r.peak_ma     = ev_peak;
        r.position    = end_pos;
        r.seek_status = phase_q;
        r.stalled     = stall_q;
        return r;
    endfunction

    function automatic int draw_gap(int pct);
        if ($urandom_range(0, 99) < pct)
            return $urandom_range(0, 19);
        return 0;
    endfunction

    function automatic void queue_cmd(logic [2:0] cmd, logic [15:0] cur, logic [15:0] duty,
                                      logic [1:0] tgt, logic [15:0] tmo);
        motor_cmd_t c;
        c.cmd  = cmd;
        c.cur  = cur;
        c.duty = duty;
        c.tgt  = tgt;
        c.tmo  = tmo;
        cmd_backlog.push_back(c);
        n_queued++;
    endfunction

    // A tick whose current has magnitude m and a random direction.
    function automatic void tick_at(int m);
        int v;
        v = (m > 32767) ? 32767 : ((m < 0) ? 0 : m);
        if ($urandom_range(0, 1))
            v = -v;
        queue_cmd(CMD_TICK, 16'(v), 16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                  16'($urandom_range(0, 65535)));
    endfunction

    function automatic logic [15:0] pick_duty();
        if ($urandom_range(0, 11) == 0)
            return 16'd0;
        return 16'($urandom_range(1, 65535));
    endfunction

    function automatic logic [15:0] pick_timeout();
        int r;
        r = $urandom_range(0, 19);
        if (r < 8)
            return 16'd0;
        if (r < 17)
            return 16'($urandom_range(5, 150));
        if (r == 17)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // Mostly complete seek strokes (inrush, running, end stop or fault), some free-run
    // stretches around the fixed threshold, and a share of fully random commands.
    function automatic void queue_random(int n);
        int stop, kind, k, lvl, len, thr, r4;
        stop = n_queued + n;
        while (n_queued < stop) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                queue_cmd(CMD_SEEK, 16'($urandom_range(0, 65535)), pick_duty(),
                          2'($urandom_range(0, 3)), pick_timeout());
                len = (gcfg.inrush_blank_ms > 12) ? 12 : gcfg.inrush_blank_ms;
                repeat ($urandom_range(0, len)) tick_at($urandom_range(300, 6000));
                lvl = $urandom_range(60, 700);
                k   = $urandom_range(0, 39);
                if (k < 20) begin
                    repeat ($urandom_range(0, 12)) tick_at(lvl + $urandom_range(0, 40));
                    repeat ($urandom_range(1, 10))
                        tick_at(($urandom_range(0, 7) == 0) ? lvl : $urandom_range(1500, 32767));
                end else if (k == 20) begin
                    repeat ($urandom_range(195, 215)) tick_at($urandom_range(0, 35));
                end else if (k < 32) begin
                    repeat ($urandom_range(5, 70)) tick_at(lvl);
                end else begin
                    repeat ($urandom_range(0, 6)) tick_at(lvl);
                    case ($urandom_range(0, 4))
                        0: queue_cmd(CMD_DRIVE, 16'd0, pick_duty(), 2'd0, 16'd0);
                        1: queue_cmd(CMD_BRAKE, 16'd0, 16'd0, 2'd0, 16'd0);
                        2: queue_cmd(CMD_COAST, 16'd0, 16'd0, 2'd0, 16'd0);
                        3: queue_cmd(CMD_CLEAR, 16'd0, 16'd0, 2'd0, 16'd0);
                        default: queue_cmd(CMD_SEEK, 16'd0, pick_duty(),
                                           2'($urandom_range(0, 3)), pick_timeout());
                    endcase
                end
            end else if (kind < 80) begin
                if ($urandom_range(0, 1))
                    queue_cmd(CMD_DRIVE, 16'($urandom_range(0, 65535)), pick_duty(),
                              2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
                thr = gcfg.stall_threshold_ma;
                if (thr == 0 || thr > 32000)
                    thr = 1500;
                r4  = $urandom_range(0, 400);
                lvl = thr - 100 + r4;
                repeat ($urandom_range(1, 14))
                    tick_at(($urandom_range(0, 3) == 0) ? $urandom_range(0, lvl) : lvl);
                case ($urandom_range(0, 3))
                    0: queue_cmd(CMD_CLEAR, 16'd0, 16'd0, 2'd0, 16'd0);
                    1: queue_cmd(CMD_BRAKE, 16'd0, 16'd0, 2'd0, 16'd0);
                    2: queue_cmd(CMD_COAST, 16'd0, 16'd0, 2'd0, 16'd0);
                    default: ;
                endcase
            end else begin
                queue_cmd(3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)),
                          16'($urandom_range(0, 65535)), 2'($urandom_range(0, 3)),
                          16'($urandom_range(0, 65535)));
            end
        end
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [15:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (idx)
            CFG_GUARD_MODE: gcfg.guard_mode         = val[0];
            CFG_STALL_THR:  gcfg.stall_threshold_ma = val;
            CFG_WINDOW:     gcfg.stall_window_ms    = val;
            CFG_RATIO:      gcfg.trip_ratio_pct     = val;
            CFG_RUN_SAMPLE: gcfg.run_sample_ms      = val;
            CFG_INRUSH:     gcfg.inrush_blank_ms    = val;
            CFG_MAX_TRAVEL: gcfg.max_travel_ms      = val;
            default:        gcfg.abs_max_ma         = val;
        endcase
    endtask

    task automatic set_guard(logic gm, logic [15:0] thr, logic [15:0] win, logic [15:0] ratio,
                             logic [15:0] run, logic [15:0] blank, logic [15:0] travel,
                             logic [15:0] ceiling);
        write_reg(CFG_GUARD_MODE, {15'd0, gm});
        write_reg(CFG_STALL_THR, thr);
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_RATIO, ratio);
        write_reg(CFG_RUN_SAMPLE, run);
        write_reg(CFG_INRUSH, blank);
        write_reg(CFG_MAX_TRAVEL, travel);
        write_reg(CFG_ABS_MAX, ceiling);
    endtask

    // Waits until every queued command went through and every status came back.
    task automatic drain();
        while (!(cmd_backlog.size() == 0 && n_taken == n_offered && status_due.size() == 0))
            @(posedge i_clk);
    endtask

    // Command driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || n_taken == n_offered) begin
            if (tx_wait > 0) begin
                tx_wait--;
                s_tvalid <= 1'b0;
            end else if (cmd_backlog.size() > 0) begin
                on_bus = cmd_backlog.pop_front();
                s_tdata  <= {6'd0, on_bus.tmo, on_bus.tgt, on_bus.duty, on_bus.cur};
                s_tuser  <= on_bus.cmd;
                s_tvalid <= 1'b1;
                n_offered++;
                tx_wait = draw_gap(tx_idle_pct);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Every accepted command is run through the model at its transaction.
    always @(posedge i_clk) begin
        if (i_rst_n && s_tvalid && s_tready) begin
            status_due.push_back(advance_motor(on_bus));
            n_taken <= n_taken + 1;
        end
    end

    // Status receiver: random back-pressure plus an occasional long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_req != hold_ack) begin
                hold_ack     = hold_req;
                rx_hold_left = HOLD_CYCLES;
            end
            if (n_status != n_status_seen) begin
                n_status_seen = n_status;
                rx_wait       = draw_gap(rx_idle_pct);
            end
            if (rx_hold_left > 0) begin
                rx_hold_left--;
                m_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    function automatic void cmp_field(int idx, string name, logic [15:0] want,
                                      logic [15:0] seen);
        if (want !== seen) begin
            mismatches++;
            if (mismatches <= 10)
                $display("status %0d: %s expected %0h, got %0h", idx, name, want, seen);
        end
    endfunction

    always @(posedge i_clk) begin : status_check
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            n_status <= n_status + 1;
            if (status_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("status %0d arrived with nothing pending", n_status);
            end else begin
                want = status_due.pop_front();
                cmp_field(n_status, "drive_mode", want.drive_mode, m_tdata[1:0]);
                cmp_field(n_status, "drive_duty", want.drive_duty, m_tdata[17:2]);
                cmp_field(n_status, "event_res", want.event_res, m_tdata[20:18]);
                cmp_field(n_status, "travel_ms", want.travel_ms, m_tdata[36:21]);
                cmp_field(n_status, "peak_ma", want.peak_ma, m_tdata[52:37]);
                cmp_field(n_status, "position", want.position, m_tdata[54:53]);
                cmp_field(n_status, "seek_status", want.seek_status, m_tdata[56:55]);
                cmp_field(n_status, "stalled", want.stalled, m_tdata[57]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_GUARD_MODE;
        i_cfg_data  = 16'd0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        reset_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: zero window, short blanking, fixed threshold of 1000 mA.
        set_guard(1'b0, 16'd1000, 16'd0, 16'd250, 16'd1, 16'd1, 16'd0, 16'd0);
        queue_cmd(CMD_SPARE6, 16'hFFFF, 16'hFFFF, 2'd3, 16'hFFFF);
        queue_cmd(CMD_SPARE7, 16'h0000, 16'h0000, 2'd0, 16'h0000);
        queue_cmd(CMD_TICK, 16'h7FFF, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_TICK, 16'h8000, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_CLEAR, 16'd0, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_DRIVE, 16'd0, 16'h7FFF, 2'd0, 16'd0);
        queue_cmd(CMD_DRIVE, 16'd0, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_SEEK, 16'd0, 16'h8000, 2'd3, 16'd3);
        queue_cmd(CMD_TICK, 16'd0, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_TICK, 16'd0, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_TICK, 16'd0, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_SEEK, 16'd0, 16'd0, 2'd1, 16'd0);
        queue_cmd(CMD_SEEK, 16'd0, 16'd100, 2'd2, 16'd0);
        queue_cmd(CMD_TICK, 16'd2000, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_TICK, 16'hF830, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_BRAKE, 16'd0, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_SEEK, 16'd0, 16'hFFFB, 2'd1, 16'hFFFF);
        queue_cmd(CMD_TICK, 16'd500, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_COAST, 16'd0, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_SEEK, 16'd0, 16'h7FFF, 2'd2, 16'd0);
        queue_cmd(CMD_DRIVE, 16'd0, 16'hFFFF, 2'd0, 16'd0);
        queue_cmd(CMD_TICK, 16'd1500, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_TICK, 16'd1500, 16'd0, 2'd0, 16'd0);
        queue_cmd(CMD_COAST, 16'd0, 16'd0, 2'd0, 16'd0);
        drain();

        // Fixed threshold with a short window; one open-circuit stroke up front.
        set_guard(1'b0, 16'd800, 16'd5, 16'd250, 16'd3, 16'd4, 16'd0, 16'd0);
        tx_idle_pct = 30;
        rx_idle_pct = 30;
        queue_cmd(CMD_SEEK, 16'd0, 16'd300, 2'd1, 16'd0);
        repeat (210) tick_at($urandom_range(0, 29));
        queue_random(250);
        hold_req++;
        drain();

        // Live ratio with a travel limit.
        set_guard(1'b1, 16'd800, 16'd4, 16'd250, 16'd6, 16'd5, 16'd60, 16'd0);
        tx_idle_pct = 60;
        rx_idle_pct = 10;
        queue_random(250);
        drain();

        // Saturating ratio threshold cut back by the ceiling.
        set_guard(1'b1, 16'd0, 16'd2, 16'hFFFF, 16'd2, 16'd3, 16'hFFFF, 16'd3000);
        tx_idle_pct = 10;
        rx_idle_pct = 60;
        queue_random(200);
        hold_req++;
        drain();

        // Smallest ratio: the threshold stays zero until the trailing minimum exceeds 99 mA.
        set_guard(1'b1, 16'd1200, 16'd1, 16'd1, 16'd1, 16'd1, 16'd40, 16'hFFFF);
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        queue_random(200);
        drain();

        // Largest settings: nothing can trip, strokes end on deadlines and aborts.
        set_guard(1'b0, 16'hFFFF, 16'hFFFF, 16'd100, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0);
        tx_idle_pct = 40;
        rx_idle_pct = 40;
        queue_random(175);
        drain();

        // Reset defaults with the fixed guard switched off.
        set_guard(1'b0, 16'd0, 16'd250, 16'd250, 16'd200, 16'd150, 16'd0, 16'd0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        queue_random(125);
        drain();

        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && status_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
